>>> src/imrq_pkg.sv
// imrq_pkg: shared types and constants for int8_matmul_requantize
// no dependencies; used by imrq_mul and the top level
package imrq_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic signed [63:0] prod_t;

	localparam logic [1:0] CFG_OUTPUT_OFFSET = 2'd0;
	localparam logic [1:0] CFG_CLAMP_LOW     = 2'd1;
	localparam logic [1:0] CFG_CLAMP_HIGH    = 2'd2;

	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7fff_ffff;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_RD   = 10'b00_0000_0010,
		ST_MUL  = 10'b00_0000_0100,
		ST_ACC  = 10'b00_0000_1000,
		ST_RQ0  = 10'b00_0001_0000,
		ST_RQ1  = 10'b00_0010_0000,
		ST_RQ2  = 10'b00_0100_0000,
		ST_RQ3  = 10'b00_1000_0000,
		ST_RQ4  = 10'b01_0000_0000,
		ST_RQ5  = 10'b10_0000_0000
	} state_t;

endpackage

>>> src/imrq_mul.sv
// imrq_mul: shared registered 32x32 signed multiplier
// depends on imrq_pkg
module imrq_mul (
	input  logic           clk,
	input  imrq_pkg::word_t a,
	input  imrq_pkg::word_t b,
	output imrq_pkg::prod_t p
);
	import imrq_pkg::*;

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= prod_t'(a) * prod_t'(b);
	end

	assign p = p_q;

endmodule

>>> src/int8_matmul_requantize.sv
// int8_matmul_requantize: int8 matrix multiply with per-channel requantization
// depends on imrq_pkg and imrq_mul
//
// channel   handshake                  payload
// in        in_valid / in_stall        cmd column position channel value last
//                                      bias multiplier shift
// out       out_valid / out_stall      result out_column out_channel final_res
// cfg       cfg_valid / cfg_ready      cfg_index cfg_data
//
// a load word is written into the column store; a weight word passes, for each
// column, through the store read port and shared multiplier, and a last weight adds
// requantization of every column on that multiplier, plus any wait on out_stall.
// reset clears control, configuration, out_valid and accumulators; the column store is not cleared.
// the output register holds one result so new words are taken while it waits.
module int8_matmul_requantize #(
	parameter int COLUMNS   = 2,
	parameter int MAX_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic        column,
	input  logic [9:0]  position,
	input  logic [15:0] channel,
	input  logic signed [7:0]  value,
	input  logic        last,
	input  imrq_pkg::word_t bias,
	input  imrq_pkg::word_t multiplier,
	input  logic signed [5:0]  shift,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [7:0]  result,
	output logic        out_column,
	output logic [15:0] out_channel,
	output logic        final_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import imrq_pkg::*;

	localparam int DEPTH = COLUMNS * MAX_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	logic signed [7:0] mem [DEPTH];
	logic signed [7:0] rdata_q;

	state_t state_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] addr_q;
	word_t acc_q [COLUMNS];

	logic signed [7:0] val_q;
	logic [15:0] chan_q;
	logic        last_q;
	word_t       mult_q;
	logic [4:0]  lsh_q;
	logic [5:0]  rsh_q;

	logic signed [7:0] offset_q, clamp_low_q, clamp_high_q;

	word_t x_q, hm_q, rd_q;
	prod_t nsum_q;
	logic  sat_q;

	logic signed [7:0] res_q;
	logic        ocol_q, ofinal_q, ovalid_q;
	logic [15:0] ochan_q;

	word_t mul_a, mul_b;
	prod_t prod;

	logic accept, in_range, col_last, out_free;
	logic [AW-1:0] load_addr;
	logic signed [32:0] div_x, div_q, div_mask, div_rem, div_thr, div_r;
	logic signed [32:0] off_sum, lo_sum, clamped;

	imrq_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_range  = (32'(position) < 32'(MAX_DEPTH));
	assign col_last  = (col_q == CW'(COLUMNS - 1));
	assign out_free  = !ovalid_q || !out_stall;
	assign load_addr = column ? AW'(MAX_DEPTH) + AW'(position) : AW'(position);
	assign cfg_ready = 1'b1;

	// shared multiplier operands
	always_comb begin
		if (state_q == ST_MUL) begin
			mul_a = word_t'(val_q);
			mul_b = word_t'(rdata_q);
		end else begin
			mul_a = x_q;
			mul_b = mult_q;
		end
	end

	// rounding divide by a power of two, half away from zero
	always_comb begin
		div_x    = 33'(hm_q);
		div_q    = div_x >>> rsh_q;
		div_mask = (33'sd1 <<< rsh_q) - 33'sd1;
		div_rem  = div_x & div_mask;
		div_thr  = (div_mask >>> 1) + 33'(hm_q[31]);
		div_r    = div_q + ((div_rem > div_thr) ? 33'sd1 : 33'sd0);
	end

	// offset and activation clamp
	always_comb begin
		off_sum = 33'(rd_q) + 33'(offset_q);
		lo_sum  = (off_sum < 33'(clamp_low_q)) ? 33'(clamp_low_q) : off_sum;
		clamped = (lo_sum > 33'(clamp_high_q)) ? 33'(clamp_high_q) : lo_sum;
	end

	// column store
	always_ff @(posedge clk) begin
		if (accept && !cmd && (32'(column) < 32'(COLUMNS)) && in_range) begin
			mem[load_addr] <= value;
		end
		rdata_q <= mem[addr_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= 8'sd0;
			clamp_low_q  <= -8'sd128;
			clamp_high_q <= 8'sd127;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OUTPUT_OFFSET: offset_q     <= cfg_data;
				CFG_CLAMP_LOW:     clamp_low_q  <= cfg_data;
				CFG_CLAMP_HIGH:    clamp_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// weight word fields
	always_ff @(posedge clk) begin
		if (accept && cmd) begin
			val_q  <= value;
			chan_q <= channel;
			last_q <= last;
			mult_q <= multiplier;
			lsh_q  <= shift[5] ? 5'd0 : shift[4:0];
			rsh_q  <= shift[5] ? 6'(-shift) : 6'd0;
		end
	end

	// requantization datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RQ0: x_q <= acc_q[col_q] << lsh_q;
			ST_RQ1: sat_q <= (x_q == WORD_MIN) && (mult_q == WORD_MIN);
			ST_RQ2: nsum_q <= prod + (prod[63] ? (64'sd1 - (64'sd1 <<< 30)) : (64'sd1 <<< 30));
			ST_RQ3: hm_q <= sat_q ? WORD_MAX
				: nsum_q[62:31] + word_t'(nsum_q[63] && (|nsum_q[30:0]));
			ST_RQ4: rd_q <= div_r[31:0];
			default: ;
		endcase
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			addr_q  <= '0;
			for (int c = 0; c < COLUMNS; c++) acc_q[c] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd) begin
						col_q  <= '0;
						addr_q <= AW'(position);
						if (position == 10'd0) begin
							for (int c = 0; c < COLUMNS; c++) acc_q[c] <= bias;
						end
						if (in_range) state_q <= ST_RD;
						else if (last) state_q <= ST_RQ0;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					acc_q[col_q] <= acc_q[col_q] + prod[31:0];
					addr_q <= addr_q + AW'(MAX_DEPTH);
					if (col_last) begin
						col_q   <= '0;
						state_q <= last_q ? ST_RQ0 : ST_IDLE;
					end else begin
						col_q   <= col_q + CW'(1);
						state_q <= ST_RD;
					end
				end
				ST_RQ0: state_q <= ST_RQ1;
				ST_RQ1: state_q <= ST_RQ2;
				ST_RQ2: state_q <= ST_RQ3;
				ST_RQ3: state_q <= ST_RQ4;
				ST_RQ4: state_q <= ST_RQ5;
				ST_RQ5: begin
					if (out_free) begin
						if (col_last) begin
							col_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							col_q   <= col_q + CW'(1);
							state_q <= ST_RQ0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_RQ5 && out_free) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RQ5 && out_free) begin
			res_q    <= clamped[7:0];
			ocol_q   <= col_q[0];
			ochan_q  <= chan_q;
			ofinal_q <= col_last;
		end
	end

	assign out_valid   = ovalid_q;
	assign result      = res_q;
	assign out_column  = ocol_q;
	assign out_channel = ochan_q;
	assign final_res   = ofinal_q;

	// a new result word only comes from the last requantization step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == ST_RQ5))
		else $error("output loaded outside requantization");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(COLUMNS))
		else $error("column counter out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> 32'(addr_q) < 32'(DEPTH))
		else $error("store read beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd && last && !in_range |=> state_q == ST_RQ0)
		else $error("last weight out of range skipped requantization");

endmodule
